[design/lsvm_pkg.sv]
// Package for the looping sample voice mixer: sizes, command and result words,
// the voice table entry and the sequencer state type.
// Depends on nothing; the top-level design file refers to it by scoped names.
package lsvm_pkg;

	localparam int VOICE_COUNT  = 4;
	localparam int MEMORY_WORDS = 65536;

	// Sample memory address width; the 16-bit word address is reduced to it
	localparam int MEM_AW = $clog2(MEMORY_WORDS);
	// Voice index width, at least one bit
	localparam int VOICE_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	// Issue counter width, able to hold VOICE_COUNT itself
	localparam int ISSUE_W = $clog2(VOICE_COUNT + 1);

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_START = 2'd1,
		OP_TICK  = 2'd2,
		OP_STOP  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic [1:0]         voice;
		logic [15:0]        mem_address;
		logic [15:0]        sample_length;
		logic               loop_enable;
		logic [15:0]        loop_offset;
		logic signed [15:0] write_data;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] mixed_sample;
		logic [3:0]         active_voices;
	} result_t;

	// One voice table entry; the active bit is held apart in flip-flops
	typedef struct packed {
		logic [15:0] base;
		logic [15:0] position;
		logic [15:0] length;
		logic        looping;
		logic [15:0] loop_point;
	} voice_entry_t;

	localparam int VOICE_ENTRY_W = $bits(voice_entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_DONE
	} seq_state_t;

endpackage

[design/lsvm_stream_if.sv]
// Valid/ready channel carrying one word of a chosen payload type.
// Depends on nothing; the payload type is given where the channel is declared.
interface lsvm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[design/lsvm_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered data.
// Depends on nothing; used for the sample memory and the voice table.
module lsvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one word, data valid the next cycle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/looping_sample_voice_mixer.sv]
// Looping sample voice mixer, top level. Uses lsvm_pkg, lsvm_stream_if and lsvm_ram.
// Holds the command sequencer, the voice read-modify-write pipeline and the mixer.
//
// A write, start or stop word is taken while idle and leaves the block ready for its
// next word. After a tick is accepted, its voices pass one per cycle through the voice
// table read, the shared sample memory read port and the accumulator; when the last
// voice is through, the result word is loaded into the output register, and the block
// takes its next word after that load. A result waiting in the output register does
// not block further write, start or stop words; a later tick holds at
// its end until the output register is free. No clearing pass runs after reset:
// voice activity lives in flip-flops, and the sample memory holds whatever was
// written to it.
module looping_sample_voice_mixer (
	input logic          clk,
	input logic          arst_n,
	lsvm_stream_if.sink   cmd,
	lsvm_stream_if.source result
);

	localparam int VW = lsvm_pkg::VOICE_W;
	localparam int AW = lsvm_pkg::MEM_AW;

	lsvm_pkg::seq_state_t state_q, state_d;

	logic                         cmd_fire;
	logic                         is_start_ok;
	logic [lsvm_pkg::VOICE_COUNT-1:0] active_q;
	logic [lsvm_pkg::ISSUE_W-1:0] issue_q;
	logic                         issue_done;
	logic                         issue_en;

	logic                         valid_s1;
	logic [VW-1:0]                idx_s1;
	logic                         valid_s2;
	logic                         act_s2;

	lsvm_pkg::voice_entry_t       vt_entry;
	lsvm_pkg::voice_entry_t       vt_wentry;
	logic [lsvm_pkg::VOICE_ENTRY_W-1:0] vt_rdata;
	logic                         vt_we;
	logic [VW-1:0]                vt_waddr;

	logic                         cur_act;
	logic [16:0]                  next_pos;
	logic                         at_end;
	logic [15:0]                  smp_addr;
	logic [15:0]                  smp_rdata;
	logic                         smp_we;

	logic [15:0]                  acc_q;
	logic                         res_valid_q;
	lsvm_pkg::result_t            res_q;
	logic [3:0]                   mask;
	logic                         load_res;

	assign cmd.ready  = (state_q == lsvm_pkg::ST_IDLE);
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign is_start_ok = (5'(cmd.data.voice) < 5'(lsvm_pkg::VOICE_COUNT));
	assign issue_done = (issue_q == lsvm_pkg::ISSUE_W'(lsvm_pkg::VOICE_COUNT));
	assign issue_en   = (state_q == lsvm_pkg::ST_TICK) && !issue_done;

	// Sample memory: written by write words, read once per voice per tick
	assign smp_we = cmd_fire && (cmd.data.operation == lsvm_pkg::OP_WRITE);

	lsvm_ram #(
		.WIDTH (16),
		.DEPTH (lsvm_pkg::MEMORY_WORDS)
	) u_sample_mem (
		.clk   (clk),
		.we    (smp_we),
		.waddr (cmd.data.mem_address[AW-1:0]),
		.wdata (cmd.data.write_data),
		.re    (valid_s1),
		.raddr (smp_addr[AW-1:0]),
		.rdata (smp_rdata)
	);

	// Voice table: start words fill an entry, ticks write back the position
	lsvm_ram #(
		.WIDTH (lsvm_pkg::VOICE_ENTRY_W),
		.DEPTH (lsvm_pkg::VOICE_COUNT)
	) u_voice_table (
		.clk   (clk),
		.we    (vt_we),
		.waddr (vt_waddr),
		.wdata (vt_wentry),
		.re    (issue_en),
		.raddr (issue_q[VW-1:0]),
		.rdata (vt_rdata)
	);

	// Stage 1: step the voice read out of the table
	always_comb begin
		vt_entry = lsvm_pkg::voice_entry_t'(vt_rdata);
		cur_act  = active_q[idx_s1];
		smp_addr = vt_entry.base + vt_entry.position;
		next_pos = {1'b0, vt_entry.position} + 17'd1;
		at_end   = (next_pos >= {1'b0, vt_entry.length});
	end

	// Choose the voice table write: start word when idle, position write-back in a tick
	always_comb begin
		vt_wentry = vt_entry;
		vt_we     = 1'b0;
		vt_waddr  = idx_s1;
		if (cmd_fire && (cmd.data.operation == lsvm_pkg::OP_START) && is_start_ok) begin
			vt_we                = 1'b1;
			vt_waddr             = VW'(cmd.data.voice);
			vt_wentry.base       = cmd.data.mem_address;
			vt_wentry.position   = 16'd0;
			vt_wentry.length     = cmd.data.sample_length;
			vt_wentry.looping    = cmd.data.loop_enable;
			vt_wentry.loop_point = cmd.data.loop_offset;
		end else if (valid_s1 && cur_act) begin
			vt_we              = 1'b1;
			vt_wentry.position = at_end ? vt_entry.loop_point : next_pos[15:0];
		end
	end

	// Voice active bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cmd_fire && (cmd.data.operation == lsvm_pkg::OP_STOP)) begin
			active_q <= '0;
		end else if (cmd_fire && (cmd.data.operation == lsvm_pkg::OP_START) && is_start_ok) begin
			active_q[VW'(cmd.data.voice)] <= 1'b1;
		end else if (valid_s1 && cur_act && at_end && !vt_entry.looping) begin
			active_q[idx_s1] <= 1'b0;
		end
	end

	// Issue counter and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q  <= '0;
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
			valid_s2 <= 1'b0;
			act_s2   <= 1'b0;
		end else begin
			if (cmd_fire && (cmd.data.operation == lsvm_pkg::OP_TICK)) begin
				issue_q <= '0;
			end else if (issue_en) begin
				issue_q <= issue_q + lsvm_pkg::ISSUE_W'(1);
			end
			valid_s1 <= issue_en;
			idx_s1   <= issue_q[VW-1:0];
			valid_s2 <= valid_s1;
			act_s2   <= valid_s1 && cur_act;
		end
	end

	// Stage 2: add the word of each active voice, wrapping to 16 bits
	always_ff @(posedge clk) begin
		if (cmd_fire && (cmd.data.operation == lsvm_pkg::OP_TICK)) begin
			acc_q <= 16'd0;
		end else if (valid_s2 && act_s2) begin
			acc_q <= acc_q + smp_rdata;
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsvm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and result load
	always_comb begin
		state_d  = state_q;
		load_res = 1'b0;
		case (state_q)
			lsvm_pkg::ST_IDLE: begin
				if (cmd_fire && (cmd.data.operation == lsvm_pkg::OP_TICK)) begin
					state_d = lsvm_pkg::ST_TICK;
				end
			end
			lsvm_pkg::ST_TICK: begin
				if (issue_done && !valid_s1 && !valid_s2) begin
					state_d = lsvm_pkg::ST_DONE;
				end
			end
			lsvm_pkg::ST_DONE: begin
				if (!res_valid_q || result.ready) begin
					load_res = 1'b1;
					state_d  = lsvm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lsvm_pkg::ST_IDLE;
			end
		endcase
	end

	// Report voices zero to three only
	always_comb begin
		mask = '0;
		for (int i = 0; i < 4; i++) begin
			if (i < lsvm_pkg::VOICE_COUNT) begin
				mask[i] = active_q[i];
			end
		end
	end

	// Output register: hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.mixed_sample  <= acc_q;
			res_q.active_voices <= mask;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	// No voice is in flight while the block takes command words
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> (!valid_s1 && !valid_s2))
		else $error("voice pipeline busy while idle");

	// A result word appears only at the end of a tick
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == lsvm_pkg::ST_DONE))
		else $error("result raised outside the end of a tick");

	// Every voice was visited before the result is formed
	a_done_all_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lsvm_pkg::ST_DONE) |-> issue_done)
		else $error("tick finished before all voices were read");

	// A new result is never loaded over one that waits untaken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |=> (res_valid_q && $stable(res_q)))
		else $error("pending result overwritten");

endmodule

[test/lsvm_mix_tracker.sv]
`timescale 1ns / 1ps
// Checker for the looping sample voice mixer testbench: mirrors the sample memory
// and the voice table and holds the mix words each tick should produce.
// Depends on lsvm_pkg for the command and result word types.
package lsvm_mix_tb_pkg;
	import lsvm_pkg::*;

	class mix_tracker;
		// Mirror of the sample memory and of which words have been written
		bit [15:0]   words [MEMORY_WORDS];
		bit          filled [MEMORY_WORDS];
		// Mirror of the voice table
		bit          voice_on [VOICE_COUNT];
		bit [15:0]   voice_start [VOICE_COUNT];
		bit [15:0]   voice_pos [VOICE_COUNT];
		bit [15:0]   voice_len [VOICE_COUNT];
		bit          voice_loops [VOICE_COUNT];
		bit [15:0]   voice_resume [VOICE_COUNT];
		// Mix words owed by ticks already taken, oldest first
		result_t     pending_mixes [$];
		int unsigned mixes_seen;
		int unsigned mismatches;

		function int unsigned word_index(bit [15:0] a);
			return int'(a) % MEMORY_WORDS;
		endfunction

		// Return the first memory word an active voice reads next that was never written
		function bit find_unwritten_read(output logic [15:0] hole);
			bit [15:0] a;
			hole = '0;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				a = voice_start[v] + voice_pos[v];
				if (voice_on[v] && !filled[word_index(a)]) begin
					hole = a;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		// Apply one accepted command word; a tick queues the mix word it produces
		function void take_command(cmd_t c);
			bit [15:0] sum;
			bit [3:0]  mask;
			bit [15:0] a;
			bit [16:0] next_pos;
			result_t   mix;
			sum = '0;
			mask = '0;
			case (c.operation)
			OP_WRITE: begin
				words[word_index(c.mem_address)] = c.write_data;
				filled[word_index(c.mem_address)] = 1'b1;
			end
			OP_START: begin
				if (int'(c.voice) < VOICE_COUNT) begin
					voice_on[c.voice]     = 1'b1;
					voice_start[c.voice]  = c.mem_address;
					voice_pos[c.voice]    = '0;
					voice_len[c.voice]    = c.sample_length;
					voice_loops[c.voice]  = c.loop_enable;
					voice_resume[c.voice] = c.loop_offset;
				end
			end
			OP_STOP: begin
				for (int v = 0; v < VOICE_COUNT; v++)
					voice_on[v] = 1'b0;
			end
			OP_TICK: begin
				// Read one word per active voice, then advance, loop or end it
				for (int v = 0; v < VOICE_COUNT; v++) begin
					if (voice_on[v]) begin
						a = voice_start[v] + voice_pos[v];
						sum = sum + words[word_index(a)];
						next_pos = {1'b0, voice_pos[v]} + 17'd1;
						if (next_pos >= {1'b0, voice_len[v]}) begin
							if (voice_loops[v])
								voice_pos[v] = voice_resume[v];
							else
								voice_on[v] = 1'b0;
						end else begin
							voice_pos[v] = next_pos[15:0];
						end
					end
				end
				for (int v = 0; v < VOICE_COUNT && v < 4; v++)
					mask[v] = voice_on[v];
				mix.mixed_sample  = sum;
				mix.active_voices = mask;
				pending_mixes.push_back(mix);
			end
			endcase
		endfunction

		task flag(string msg);
			$display("ERROR: %s", msg);
			mismatches++;
		endtask

		// Compare one accepted mix word with the oldest one owed
		task compare_mix(result_t got);
			result_t want;
			if (pending_mixes.size() == 0) begin
				flag($sformatf("mix word %h arrived with none owed", got));
			end else begin
				want = pending_mixes.pop_front();
				if (got.mixed_sample !== want.mixed_sample)
					flag($sformatf("tick %0d: mixed_sample %0d, want %0d",
						mixes_seen, got.mixed_sample, want.mixed_sample));
				if (got.active_voices !== want.active_voices)
					flag($sformatf("tick %0d: active_voices %b, want %b",
						mixes_seen, got.active_voices, want.active_voices));
			end
			mixes_seen++;
		endtask
	endclass

endpackage

[test/tb_looping_sample_voice_mixer.sv]
`timescale 1ns / 1ps
// Testbench top for the looping sample voice mixer: directed and random command
// words with bursty input and a stalling output. Depends on lsvm_pkg,
// lsvm_stream_if, the mixer RTL and the mix_tracker checker.
module tb_looping_sample_voice_mixer;
	import lsvm_pkg::*;
	import lsvm_mix_tb_pkg::*;

	localparam int unsigned COMMAND_TARGET   = 1900;
	localparam int unsigned HOLD_AT_WORD     = 700;
	localparam int unsigned DRAIN_AT_WORD    = 1300;
	localparam int unsigned LONG_HOLD_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES    = 20;
	localparam int unsigned CYCLE_LIMIT      = 400000;

	logic clk;
	logic arst_n;

	lsvm_stream_if #(.payload_t(cmd_t))    cmd_ch ();
	lsvm_stream_if #(.payload_t(result_t)) result_ch ();

	mix_tracker  tracker;
	int unsigned sent_count = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	bit          long_hold_req = 1'b0;
	cmd_t        directed_q [$];

	looping_sample_voice_mixer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.result (result_ch)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Check every accepted mix word
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_ch.valid && result_ch.ready)
			tracker.compare_mix(result_ch.data);
	end

	// Stall the output on a rotating pattern per phase; honor one long hold-off
	initial begin
		int unsigned hold_left;
		int unsigned phase_left;
		logic [7:0]  pattern;
		bit          steady;
		hold_left = 0;
		phase_left = 0;
		pattern = 8'hff;
		steady = 1'b1;
		result_ch.ready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (hold_left != 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD_CYCLES - 1;
				result_ch.ready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					phase_left = $urandom_range(16, 160);
					steady = ($urandom_range(0, 3) == 0);
					pattern = 8'($urandom) | 8'h01;
				end
				phase_left--;
				result_ch.ready <= steady | pattern[0];
				pattern = {pattern[0], pattern[7:1]};
			end
			@(posedge clk);
		end
	end

	function automatic cmd_t make_cmd(op_t op, logic [1:0] v, logic [15:0] addr,
			logic [15:0] len, logic loop_en, logic [15:0] loop_off, logic [15:0] data);
		cmd_t c;
		c.operation     = op;
		c.voice         = v;
		c.mem_address   = addr;
		c.sample_length = len;
		c.loop_enable   = loop_en;
		c.loop_offset   = loop_off;
		c.write_data    = data;
		return c;
	endfunction

	function automatic cmd_t random_fields();
		return make_cmd(op_t'($urandom_range(0, 3)), 2'($urandom), 16'($urandom),
			16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	// Most voices play out of a small region that wraps past the top of memory
	function automatic logic [15:0] pool_address();
		return 16'hffc0 + 16'($urandom_range(0, 127));
	endfunction

	function automatic cmd_t random_command();
		cmd_t        c;
		int unsigned pick;
		int unsigned reach;
		c = random_fields();
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			c.operation = OP_WRITE;
			if ($urandom_range(0, 9) < 6)
				c.mem_address = pool_address();
			if ($urandom_range(0, 15) == 0)
				c.write_data = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
		end else if (pick < 38) begin
			c.operation = OP_START;
			if ($urandom_range(0, 9) < 7)
				c.mem_address = pool_address();
			case ($urandom_range(0, 9))
			0: c.sample_length = '0;
			1: c.sample_length = 16'hffff;
			2: ;
			default: c.sample_length = 16'($urandom_range(1, 12));
			endcase
			reach = (c.sample_length == 0) ? 1 : c.sample_length;
			case ($urandom_range(0, 9))
			// resume at or past the end, so the same word repeats
			0, 1: c.loop_offset = 16'(reach + $urandom_range(0, 4));
			2: c.loop_offset = 16'hffff;
			3: ;
			default: c.loop_offset = 16'($urandom_range(0, reach - 1));
			endcase
		end else if (pick < 97) begin
			c.operation = OP_TICK;
		end else begin
			c.operation = OP_STOP;
		end
		return c;
	endfunction

	// Offer one word, hold it until taken, then maybe end the burst with a gap
	task automatic send_command(input cmd_t c);
		int unsigned gap;
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		do
			@(posedge clk);
		while (!(cmd_ch.valid && cmd_ch.ready));
		tracker.take_command(c);
		sent_count++;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Before a tick, write every word an active voice is about to read for the first time
	task automatic issue(input cmd_t c);
		logic [15:0] hole;
		cmd_t        fill;
		if (c.operation == OP_TICK) begin
			while (tracker.find_unwritten_read(hole)) begin
				fill = random_fields();
				fill.operation = OP_WRITE;
				fill.mem_address = hole;
				send_command(fill);
			end
		end
		send_command(c);
	endtask

	initial begin
		bit hold_asked;
		bit drain_done;
		hold_asked = 1'b0;
		drain_done = 1'b0;
		tracker = new();
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle tick, address wrap, zero length, sum overflow, loop past the end,
		// full-scale fields, restart of a stopped voice, stop all
		directed_q.push_back(make_cmd(OP_WRITE, 2'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h7fff));
		directed_q.push_back(make_cmd(OP_WRITE, 2'd0, 16'hffff, 16'h0000, 1'b0, 16'h0000, 16'h7fff));
		directed_q.push_back(make_cmd(OP_WRITE, 2'd0, 16'h0001, 16'h0000, 1'b0, 16'h0000, 16'h8000));
		directed_q.push_back(make_cmd(OP_WRITE, 2'd0, 16'h0002, 16'h0000, 1'b0, 16'h0000, 16'hffff));
		directed_q.push_back(make_cmd(OP_TICK, 2'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000));
		directed_q.push_back(make_cmd(OP_START, 2'd0, 16'hffff, 16'd3, 1'b0, 16'h0000, 16'h0000));
		directed_q.push_back(make_cmd(OP_START, 2'd1, 16'h0000, 16'd0, 1'b0, 16'h0000, 16'h0000));
		directed_q.push_back(make_cmd(OP_TICK, 2'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000));
		directed_q.push_back(make_cmd(OP_START, 2'd2, 16'h0001, 16'd2, 1'b1, 16'd5, 16'h0000));
		directed_q.push_back(make_cmd(OP_START, 2'd3, 16'hffff, 16'hffff, 1'b1, 16'hffff, 16'hffff));
		directed_q.push_back(make_cmd(OP_TICK, 2'd3, 16'hffff, 16'hffff, 1'b1, 16'hffff, 16'hffff));
		directed_q.push_back(make_cmd(OP_TICK, 2'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000));
		directed_q.push_back(make_cmd(OP_START, 2'd0, 16'h0002, 16'd1, 1'b1, 16'd0, 16'h0000));
		directed_q.push_back(make_cmd(OP_TICK, 2'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000));
		directed_q.push_back(make_cmd(OP_TICK, 2'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000));
		directed_q.push_back(make_cmd(OP_TICK, 2'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000));
		directed_q.push_back(make_cmd(OP_STOP, 2'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000));
		directed_q.push_back(make_cmd(OP_TICK, 2'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000));
		directed_q.push_back(make_cmd(OP_START, 2'd1, 16'h8000, 16'd1, 1'b0, 16'h0000, 16'h0000));
		directed_q.push_back(make_cmd(OP_TICK, 2'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000));
		directed_q.push_back(make_cmd(OP_START, 2'd3, 16'hffff, 16'd2, 1'b1, 16'd1, 16'h0000));
		directed_q.push_back(make_cmd(OP_TICK, 2'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000));
		directed_q.push_back(make_cmd(OP_TICK, 2'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000));
		foreach (directed_q[i])
			issue(directed_q[i]);

		// Random: keep offering words, with one long output hold-off and one full drain
		while (sent_count < COMMAND_TARGET) begin
			if (!hold_asked && sent_count >= HOLD_AT_WORD) begin
				hold_asked = 1'b1;
				long_hold_req = 1'b1;
			end
			if (!drain_done && sent_count >= DRAIN_AT_WORD) begin
				drain_done = 1'b1;
				cmd_ch.valid <= 1'b0;
				do
					@(posedge clk);
				while (tracker.pending_mixes.size() != 0);
			end
			issue(random_command());
		end
		cmd_ch.valid <= 1'b0;

		// Wait out the owed mix words, then watch for strays
		do
			@(posedge clk);
		while (tracker.pending_mixes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_mixes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[looping_sample_voice_mixer.f]
design/lsvm_pkg.sv
design/lsvm_stream_if.sv
design/lsvm_ram.sv
design/looping_sample_voice_mixer.sv
test/lsvm_mix_tracker.sv
test/tb_looping_sample_voice_mixer.sv
